FILE: rtl/srb_pkg.sv
// Shared types, defaults and character helpers for the signature range blesser.
// No dependencies; srb_cell, the top level and the testbench import this package.
`default_nettype none
package srb_pkg;

  localparam int unsigned NUM_SIGNATURES_DEF = 16;
  localparam int unsigned MAX_SIG_LEN_DEF    = 32;

  // per-cycle control broadcast along the window cells
  typedef struct packed {
    logic shift;      // new command byte enters at cell 0
    logic bless;      // current signature matched: clear marks in span
    logic clear;      // command done: all marks back to tainted
    logic fold_case;  // compare ignoring ASCII letter case
  } cell_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/srb_in_if.sv
// Input channel: load or command byte with valid/ready.
// No dependencies.
`default_nettype none
interface srb_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_value;
  logic       last;
  modport source (output valid, op, byte_value, last, input ready);
  modport sink   (input valid, op, byte_value, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/srb_out_if.sv
// Output channel: one mark per command byte with valid/ready.
// No dependencies.
`default_nettype none
interface srb_out_if;
  logic valid;
  logic ready;
  logic mark;
  logic end_of_command;
  modport source (output valid, mark, end_of_command, input ready);
  modport sink   (input valid, mark, end_of_command, output ready);
endinterface
`default_nettype wire

FILE: rtl/srb_cfg_if.sv
// Configuration write channel for the exact-compare register.
// No dependencies.
`default_nettype none
interface srb_cfg_if;
  logic valid;
  logic ready;
  logic cmp_exact;
  modport source (output valid, cmp_exact, input ready);
  modport sink   (input valid, cmp_exact, output ready);
endinterface
`default_nettype wire

FILE: rtl/srb_sig_mem.sv
// Signature table: one row per signature, {length, reversed bytes}.
// Single write port, one registered read port. Uses no package.
`default_nettype none
module srb_sig_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 262
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/srb_cell.sv
// One window cell: a command byte and its mark, shifting to the next cell.
// Depends on srb_pkg for cell_ctl_t and fold_byte.
`default_nettype none
module srb_cell
  import srb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctl_t  ctl_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       mark_i,
  input  wire logic [7:0] sig_byte_i,
  input  wire logic       in_span_i,
  output logic      [7:0] byte_o,
  output logic            mark_o,
  output logic            ok_o
);

  logic [7:0] byte_q;
  logic       mark_q;
  logic [7:0] a, b;

  always_comb begin
    a = ctl_i.fold_case ? fold_byte(byte_q) : byte_q;
    b = ctl_i.fold_case ? fold_byte(sig_byte_i) : sig_byte_i;
  end

  assign ok_o   = ~in_span_i | (a == b);
  assign byte_o = byte_q;
  assign mark_o = mark_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b1;
    end else if (ctl_i.clear) begin
      mark_q <= 1'b1;
    end else if (ctl_i.shift) begin
      mark_q <= mark_i;
    end else if (ctl_i.bless && in_span_i) begin
      mark_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/signature_range_blesser_unit.sv
// Signature range blesser top level: load path, window cell chain, scan control.
// Depends on srb_pkg, srb_in_if, srb_out_if, srb_cfg_if, srb_cell, srb_sig_mem.
//
// Load items fill a signature table; command bytes enter a chain of MAX_SIG_LEN
// cells, newest at cell 0, and each stored signature is tested against the tail
// of the window, in turn (table read, then compare across all cells). The
// input takes no new item while a command byte is scanned or its marks are
// released, and a release waits on the sink; the table's single read port is
// why signatures are tested in turn. A byte releases the oldest mark once the
// window is full; a last byte flushes all held marks, oldest first. No clearing
// pass: the table is read only at rows already written.
`default_nettype none
module signature_range_blesser_unit
  import srb_pkg::*;
#(
  parameter int unsigned NUM_SIGNATURES = NUM_SIGNATURES_DEF,
  parameter int unsigned MAX_SIG_LEN    = MAX_SIG_LEN_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srb_in_if.sink     in_ch_i,
  srb_out_if.source  out_ch_o,
  srb_cfg_if.sink    cfg_ch_i
);

  localparam int unsigned CNT_W   = $clog2(NUM_SIGNATURES + 1);
  localparam int unsigned SADDR_W = (NUM_SIGNATURES > 1) ? $clog2(NUM_SIGNATURES) : 1;
  localparam int unsigned LEN_W   = $clog2(MAX_SIG_LEN + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_SIG_LEN);
  localparam int unsigned BYTES_W = MAX_SIG_LEN * 8;
  localparam int unsigned ROW_W   = BYTES_W + LEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_FIN, S_EMIT_ONE, S_FLUSH
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   sig_cnt_q, sidx_q, sidx_nx;
  logic               loaded_q, cs_q, last_q;
  logic [LEN_W-1:0]   pend_len_q, fill_q;
  logic [7:0]         ld_buf_q [MAX_SIG_LEN];
  logic [7:0]         ld_buf_d [MAX_SIG_LEN];
  logic [IDX_W-1:0]   fl_idx_q;
  logic               out_valid_q, out_mark_q, out_eoc_q;

  logic               in_fire, out_fire, ld_room;
  logic               mem_we;
  logic [ROW_W-1:0]   wr_row, rd_row;
  logic [LEN_W-1:0]   rd_len, pend_len_d;

  logic [7:0]         cell_byte [MAX_SIG_LEN];
  logic               cell_mark [MAX_SIG_LEN];
  logic [MAX_SIG_LEN-1:0] cell_ok;
  logic               in_span [MAX_SIG_LEN];
  logic               match;
  cell_ctl_t          ctl;

  assign in_ch_i.ready    = (state_q == S_IDLE);
  assign cfg_ch_i.ready   = 1'b1;
  assign out_ch_o.valid   = out_valid_q;
  assign out_ch_o.mark    = out_mark_q;
  assign out_ch_o.end_of_command = out_eoc_q;

  assign in_fire  = in_ch_i.valid & in_ch_i.ready;
  assign out_fire = out_valid_q & out_ch_o.ready;
  assign sidx_nx  = sidx_q + CNT_W'(1);

  // load path: newest byte at position 0 so rows line up with the window
  assign ld_room = (pend_len_q < LEN_W'(MAX_SIG_LEN));
  always_comb begin
    for (int j = 0; j < MAX_SIG_LEN; j++) begin
      if (!ld_room) ld_buf_d[j] = ld_buf_q[j];
      else if (j == 0) ld_buf_d[j] = in_ch_i.byte_value;
      else ld_buf_d[j] = ld_buf_q[j-1];
    end
    pend_len_d = ld_room ? pend_len_q + LEN_W'(1) : pend_len_q;
    for (int j = 0; j < MAX_SIG_LEN; j++) begin
      wr_row[j*8 +: 8] = ld_buf_d[j];
    end
    wr_row[ROW_W-1 -: LEN_W] = pend_len_d;
  end

  assign mem_we = in_fire & ~in_ch_i.op & in_ch_i.last &
                  (sig_cnt_q < CNT_W'(NUM_SIGNATURES));

  srb_sig_mem #(
    .DEPTH  (NUM_SIGNATURES),
    .ADDR_W (SADDR_W),
    .DATA_W (ROW_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (sig_cnt_q[SADDR_W-1:0]),
    .wr_data_i (wr_row),
    .rd_addr_i (sidx_q[SADDR_W-1:0]),
    .rd_data_o (rd_row)
  );

  assign rd_len = rd_row[ROW_W-1 -: LEN_W];

  always_comb begin
    ctl.shift     = in_fire & in_ch_i.op;
    ctl.bless     = (state_q == S_CMP) & match;
    ctl.clear     = (state_q == S_FLUSH) & out_fire & out_eoc_q;
    ctl.fold_case = ~cs_q;
  end

  for (genvar j = 0; j < MAX_SIG_LEN; j++) begin : g_cell
    assign in_span[j] = (LEN_W'(j) < rd_len);
    srb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .byte_i     ((j == 0) ? in_ch_i.byte_value : cell_byte[(j == 0) ? 0 : j-1]),
      .mark_i     ((j == 0) ? loaded_q : cell_mark[(j == 0) ? 0 : j-1]),
      .sig_byte_i (rd_row[j*8 +: 8]),
      .in_span_i  (in_span[j]),
      .byte_o     (cell_byte[j]),
      .mark_o     (cell_mark[j]),
      .ok_o       (cell_ok[j])
    );
  end

  // one-byte signatures that are a letter never match
  assign match = (rd_len != '0) && (rd_len <= fill_q) && (&cell_ok) &&
                 !((rd_len == LEN_W'(1)) && is_letter(rd_row[7:0]));

  always_ff @(posedge clk_i) begin
    if (in_fire && !in_ch_i.op && (sig_cnt_q < CNT_W'(NUM_SIGNATURES))) begin
      ld_buf_q <= ld_buf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sig_cnt_q   <= '0;
      sidx_q      <= '0;
      loaded_q    <= 1'b0;
      cs_q        <= 1'b1;
      last_q      <= 1'b0;
      pend_len_q  <= '0;
      fill_q      <= '0;
      fl_idx_q    <= '0;
      out_valid_q <= 1'b0;
      out_mark_q  <= 1'b1;
      out_eoc_q   <= 1'b0;
    end else begin
      if (cfg_ch_i.valid) begin
        cs_q <= cfg_ch_i.cmp_exact;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (!in_ch_i.op) begin
              loaded_q <= 1'b1;
              if (sig_cnt_q < CNT_W'(NUM_SIGNATURES)) begin
                if (in_ch_i.last) begin
                  sig_cnt_q  <= sig_cnt_q + CNT_W'(1);
                  pend_len_q <= '0;
                end else begin
                  pend_len_q <= pend_len_d;
                end
              end
            end else begin
              fill_q  <= fill_q + LEN_W'(1);
              last_q  <= in_ch_i.last;
              sidx_q  <= '0;
              state_q <= (sig_cnt_q != '0) ? S_RD : S_FIN;
            end
          end
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          sidx_q  <= sidx_nx;
          state_q <= (sidx_nx < sig_cnt_q) ? S_RD : S_FIN;
        end
        S_FIN: begin
          if (last_q) begin
            fl_idx_q    <= IDX_W'(fill_q - LEN_W'(1));
            out_mark_q  <= cell_mark[IDX_W'(fill_q - LEN_W'(1))];
            out_eoc_q   <= (fill_q == LEN_W'(1));
            out_valid_q <= 1'b1;
            state_q     <= S_FLUSH;
          end else if (fill_q == LEN_W'(MAX_SIG_LEN)) begin
            out_mark_q  <= cell_mark[MAX_SIG_LEN-1];
            out_eoc_q   <= 1'b0;
            out_valid_q <= 1'b1;
            fill_q      <= LEN_W'(MAX_SIG_LEN - 1);
            state_q     <= S_EMIT_ONE;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT_ONE: begin
          if (out_fire) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_fire) begin
            if (out_eoc_q) begin
              out_valid_q <= 1'b0;
              out_eoc_q   <= 1'b0;
              fill_q      <= '0;
              state_q     <= S_IDLE;
            end else begin
              fl_idx_q   <= fl_idx_q - IDX_W'(1);
              out_mark_q <= cell_mark[fl_idx_q - IDX_W'(1)];
              out_eoc_q  <= (fl_idx_q == IDX_W'(1));
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb_signature_range_blesser_unit.sv
// Testbench for signature_range_blesser_unit: signature loads, command streams, case folding.
// Depends on srb_pkg and the srb_in_if, srb_out_if and srb_cfg_if interfaces.
`timescale 1ns / 1ps
module tb_signature_range_blesser_unit;
  import srb_pkg::*;

  localparam int NSIG = NUM_SIGNATURES_DEF;
  localparam int SLEN = MAX_SIG_LEN_DEF;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CMD  = 1'b1;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic mark;
    logic eoc;
  } mark_t;

  class mark_board;
    logic [7:0] sig_mem [NSIG][SLEN];
    int sig_len [NSIG];
    int sig_cnt;
    bit loaded;
    int load_len;
    logic [7:0] win_b [SLEN];
    logic win_m [SLEN];
    int win_fill;
    bit exact;
    mark_t due [$];
    int errors;

    function new();
      sig_cnt = 0; loaded = 0; load_len = 0; win_fill = 0; exact = 1; errors = 0;
      foreach (win_m[i]) win_m[i] = 1'b1;
    endfunction

    function logic [7:0] lower(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function bit alpha(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function void note_input(logic op, logic [7:0] b, logic lst);
      int base;
      bit hit;
      mark_t r;
      if (op == OP_LOAD) begin
        loaded = 1;
        if (sig_cnt >= NSIG) return;
        if (load_len < SLEN) begin
          sig_mem[sig_cnt][load_len] = b;
          load_len++;
        end
        if (lst) begin
          sig_len[sig_cnt] = load_len;
          sig_cnt++;
          load_len = 0;
        end
        return;
      end
      win_b[win_fill] = b;
      win_m[win_fill] = loaded;
      win_fill++;
      for (int s = 0; s < sig_cnt; s++) begin
        if (sig_len[s] == 0 || sig_len[s] > win_fill) continue;
        if (sig_len[s] == 1 && alpha(sig_mem[s][0])) continue;
        base = win_fill - sig_len[s];
        hit = 1;
        for (int k = 0; k < sig_len[s]; k++)
          if (exact ? win_b[base+k] != sig_mem[s][k]
                    : lower(win_b[base+k]) != lower(sig_mem[s][k])) hit = 0;
        if (hit) for (int k = base; k < win_fill; k++) win_m[k] = 1'b0;
      end
      if (lst) begin
        for (int k = 0; k < win_fill; k++) begin
          r.mark = win_m[k]; r.eoc = (k + 1 == win_fill);
          due.insert(due.size(), r);
        end
        win_fill = 0;
        foreach (win_m[i]) win_m[i] = 1'b1;
      end else if (win_fill >= SLEN) begin
        r.mark = win_m[0]; r.eoc = 1'b0;
        due.insert(due.size(), r);
        for (int k = 0; k < SLEN - 1; k++) begin
          win_b[k] = win_b[k+1]; win_m[k] = win_m[k+1];
        end
        win_fill = SLEN - 1;
        win_b[win_fill] = 8'h00; win_m[win_fill] = 1'b1;
      end
    endfunction

    function void check_mark(logic mk, logic eoc);
      mark_t e;
      if (due.size() == 0) begin
        $error("unexpected mark transfer: mark %0d end_of_command %0d", mk, eoc);
        errors++;
        return;
      end
      e = due.pop_front();
      if (mk !== e.mark) begin
        $error("mark: expected %0d actual %0d", e.mark, mk); errors++;
      end
      if (eoc !== e.eoc) begin
        $error("end_of_command: expected %0d actual %0d", e.eoc, eoc); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  srb_in_if  in_ch ();
  srb_out_if out_ch ();
  srb_cfg_if cfg_ch ();

  signature_range_blesser_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_ch_i(in_ch.sink), .out_ch_o(out_ch.source), .cfg_ch_i(cfg_ch.sink)
  );

  mark_board board = new();
  int send_idle = 28;
  int recv_idle = 75;
  bit recv_hold = 0;
  int quiet = 0;

  initial begin
    in_ch.valid = 1'b0; in_ch.op = OP_LOAD; in_ch.byte_value = 8'h01; in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.cmp_exact = 1'b1;
  end

  // receiver: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) board.check_mark(out_ch.mark, out_ch.end_of_command);
      out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("signature_range_blesser_unit test failed");
      $finish;
    end
  end

  // valid stays high after a transfer; the next item or an idle cycle replaces it
  task automatic send_item(logic op, logic [7:0] b, logic lst);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1; in_ch.op <= op; in_ch.byte_value <= b; in_ch.last <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_input(op, b, lst);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    // a command byte may still be under compare; give the block room to settle
    repeat (2 * (2 + 2 * NSIG) + 8) @(posedge clk_i);
  endtask

  task automatic write_case(logic v);
    drain();
    cfg_ch.valid <= 1'b1; cfg_ch.cmp_exact <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    board.exact = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_string(logic op, string s, logic close);
    for (int i = 0; i < s.len(); i++)
      send_item(op, s[i], close && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(3))
      0: return 8'(8'h61 + $urandom_range(2));
      1: return 8'(8'h41 + $urandom_range(2));
      2: return 8'(8'h30 + $urandom_range(1));
      default: return 8'($urandom_range(255, 1));
    endcase
  endfunction

  string sigs [$];

  task automatic random_command(int len);
    string s;
    int p;
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      if (sigs.size() != 0 && $urandom_range(3) == 0) begin
        s = sigs[$urandom_range(sigs.size() - 1)];
        for (int k = 0; k < s.len(); k++) begin
          c = s[k];
          if ($urandom_range(1) && c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
          send_item(OP_CMD, c, 1'b0);
        end
      end
      c = pick_char();
      send_item(OP_CMD, c, i == len - 1);
    end
  endtask

  task automatic load_random_sig();
    string s;
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(34, 30) : $urandom_range(5, 1);
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(pick_char())};
    sigs.insert(sigs.size(), s);
    send_string(OP_LOAD, s, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no table yet: everything blessed, including a long command
    send_item(OP_CMD, 8'hFF, 1'b0);
    send_item(OP_CMD, 8'h01, 1'b1);
    for (int i = 0; i < 34; i++) send_item(OP_CMD, 8'(128 + i), i == 33);
    write_case(1'b1);

    // bytes entered before the first load keep their blessing
    send_item(OP_CMD, 8'h7A, 1'b0);
    send_string(OP_LOAD, "ab", 1'b1);
    send_string(OP_LOAD, "x", 1'b1);        // single letter never matches
    send_string(OP_LOAD, "%", 1'b1);        // single non-letter does
    send_string(OP_LOAD, "zz", 1'b0);       // unclosed while command runs
    send_string(OP_CMD, "abxAB%", 1'b1);
    send_item(OP_LOAD, 8'h01, 1'b1);
    sigs.insert(sigs.size(), "ab"); sigs.insert(sigs.size(), "%");
    sigs.insert(sigs.size(), "zz");
    write_case(1'b0);
    send_string(OP_CMD, "xABzZ", 1'b1);
    write_case(1'b1);

    // receiver holds off while the sender keeps offering
    recv_hold = 1;
    fork
      random_command(40);
      begin repeat (300) @(posedge clk_i); recv_hold = 0; end
    join

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 28 : (phase == 1) ? 75 : 0;
      recv_idle = (phase == 0) ? 75 : (phase == 1) ? 28 : 0;
      for (int j = 0; j < 3; j++) begin
        if ($urandom_range(2) == 0) load_random_sig();
        random_command($urandom_range(9, 1));
        if (j == 1) drain();
      end
      write_case(phase[0]);
    end
    send_idle = 0; recv_idle = 0;
    // overflow the table then check it still works
    for (int i = 0; i < 18; i++) send_item(OP_LOAD, 8'(33 + i), 1'b1);
    random_command(10);
    drain();
    if (board.errors == 0) $display("signature_range_blesser_unit test passed");
    else $display("signature_range_blesser_unit test failed");
    $finish;
  end
endmodule

FILE: sim.f
rtl/srb_pkg.sv
rtl/srb_in_if.sv
rtl/srb_out_if.sv
rtl/srb_cfg_if.sv
rtl/srb_sig_mem.sv
rtl/srb_cell.sv
rtl/signature_range_blesser_unit.sv
bench/tb_signature_range_blesser_unit.sv
